### rtl/ppm_pkg.sv
// ppm_pkg: shared types and constants for the ppm frame decoder
// request payloads, result payloads, op and edge class codes, register map
// no dependencies; imported by every module of the decoder
package ppm_pkg;

  localparam int US_W     = 15;
  localparam int MARGIN_W = 10;
  localparam int TICK_W   = 16;
  localparam int REM_W    = 4;
  localparam int CFG_W    = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_OUT_W = 4;
  localparam int IDX_IN_W  = 3;

  // tick to microsecond scale: us = ticks * TICK_NUM / TICK_DEN
  localparam logic [REM_W-1:0] TICK_NUM = 4'd4;
  localparam logic [REM_W-1:0] TICK_DEN = 4'd10;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_GLITCH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 3'd4;

  // register reset values
  localparam logic [US_W-1:0]     GLITCH_RST = 15'd300;
  localparam logic [US_W-1:0]     SYNC_RST   = 15'd3000;
  localparam logic [US_W-1:0]     MIN_RST    = 15'd1000;
  localparam logic [US_W-1:0]     MAX_RST    = 15'd2000;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 10'd20;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_EDGE = 2'd1,
    OP_READ = 2'd2,
    OP_ARM  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CLS_DISARMED = 3'd0,
    CLS_GLITCH   = 3'd1,
    CLS_STORED   = 3'd2,
    CLS_DROPPED  = 3'd3,
    CLS_SYNC     = 3'd4
  } edge_class_t;

  typedef struct packed {
    op_t                 op;
    logic [IDX_IN_W-1:0] channel_index;
  } item_t;

  typedef struct packed {
    logic [US_W-1:0]      read_value;
    logic [US_W-1:0]      interval_us;
    edge_class_t          edge_class;
    logic                 frame_ready;
    logic                 armed;
    logic [CNT_OUT_W-1:0] channel_count;
  } result_t;

  typedef struct packed {
    logic tick;
    logic clear;
  } timer_ctl_t;

endpackage

### rtl/ppm_timer.sv
// ppm_timer: free-running tick counter with an incremental microsecond view
// keeps quotient and remainder of ticks*4/10 so no divider is needed
// depends on ppm_pkg
module ppm_timer #(
  parameter int RELOAD = 50000
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ppm_pkg::timer_ctl_t      ctl,
  output logic [ppm_pkg::US_W-1:0] us
);
  import ppm_pkg::*;

  localparam logic [TICK_W-1:0] LAST = TICK_W'(RELOAD - 1);

  logic [TICK_W-1:0] tick_count;
  logic [US_W-1:0]   us_q;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_sum;

  assign rem_sum = rem + TICK_NUM;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      tick_count <= '0;
      us_q       <= '0;
      rem        <= '0;
    end else if (ctl.tick) begin
      if (tick_count >= LAST) begin
        tick_count <= '0;
        us_q       <= '0;
        rem        <= '0;
      end else begin
        tick_count <= tick_count + 1'b1;
        if (rem_sum >= TICK_DEN) begin
          rem  <= rem_sum - TICK_DEN;
          us_q <= us_q + 1'b1;
        end else begin
          rem  <= rem_sum;
        end
      end
    end
  end

  assign us = us_q;

  // remainder stays a proper digit
  a_rem_range: assert property (@(posedge clk) disable iff (rst) rem < TICK_DEN)
    else $error("timer remainder out of range");

  // counter and microsecond view clear together
  a_zero_sync: assert property (@(posedge clk) disable iff (rst)
    (tick_count == '0) == ((us_q == '0) && (rem == '0)))
    else $error("timer views out of step");

endmodule

### rtl/ppm_snap.sv
// ppm_snap: snaps a pulse width to the min or max end and offsets it by min
// purely combinational, saturates at zero when max lies below min
// depends on ppm_pkg
module ppm_snap (
  input  logic [ppm_pkg::US_W-1:0]     us,
  input  logic [ppm_pkg::US_W-1:0]     min_us,
  input  logic [ppm_pkg::US_W-1:0]     max_us,
  input  logic [ppm_pkg::MARGIN_W-1:0] margin_us,
  output logic [ppm_pkg::US_W-1:0]     value
);
  import ppm_pkg::*;

  logic [US_W:0]          lo_lim;
  logic signed [US_W+1:0] hi_lim;
  logic [US_W-1:0]        snap_lo;
  logic [US_W-1:0]        snap_hi;

  always_comb begin
    lo_lim  = {1'b0, min_us} + (US_W+1)'(margin_us);
    hi_lim  = $signed({2'b00, max_us}) - $signed((US_W+2)'(margin_us));
    snap_lo = ({1'b0, us} < lo_lim) ? min_us : us;
    snap_hi = ($signed({2'b00, snap_lo}) > hi_lim) ? max_us : snap_lo;
    value   = (snap_hi >= min_us) ? (snap_hi - min_us) : '0;
  end

endmodule

### rtl/ppm_store.sv
// ppm_store: channel value store, one write and one read port
// cleared at reset, reads past the channel count return zero
// depends on ppm_pkg
module ppm_store #(
  parameter int MAX_CHANNELS = 8,
  parameter int IDX_W        = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         we,
  input  logic [IDX_W-1:0]             waddr,
  input  logic [ppm_pkg::US_W-1:0]     wdata,
  input  logic [ppm_pkg::IDX_IN_W-1:0] rindex,
  output logic [ppm_pkg::US_W-1:0]     rdata
);
  import ppm_pkg::*;

  logic [US_W-1:0]           chan [MAX_CHANNELS];
  logic [IDX_W+IDX_IN_W-1:0] ridx_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        chan[i] <= '0;
      end
    end else if (we) begin
      chan[waddr] <= wdata;
    end
  end

  always_comb begin
    ridx_wide = (IDX_W+IDX_IN_W)'(rindex);
    if (int'(rindex) < MAX_CHANNELS) begin
      rdata = chan[ridx_wide[IDX_W-1:0]];
    end else begin
      rdata = '0;
    end
  end

endmodule

### rtl/ppm_frame_decoder.sv
// ppm_frame_decoder: top level of the rc ppm frame decoder
// holds the request stage, frame control, registers and result stage
// depends on ppm_pkg, ppm_timer, ppm_snap, ppm_store
//
// usage
//   item channel (item_valid / item_stall / item) carries one request per
//   accepted cycle: timer tick, rising edge, channel read or arm.
//   result channel (result_valid / result_stall / result) returns one result
//   for every edge, read and arm request; ticks give none.
//   cfg_we / cfg_index / cfg_data write a threshold register;
//   write only while no request is in flight.
// timing
//   a request is taken into a request register, then processed in one pass
//   and its result lands in the result register, which drives result_valid.
//   one request per cycle is sustained while the result is not stalled;
//   the frame state, the tick counter and the channel store all update in
//   that single pass.
// reset
//   synchronous rst clears both stages, the tick counter, the store, the
//   channel index and the flags (disarmed), and loads register defaults.
// stall
//   a stalled result holds; the request stage keeps taking ticks, and takes
//   one more request behind it before item_stall rises.
module ppm_frame_decoder #(
  parameter int MAX_CHANNELS = 8,
  parameter int RELOAD       = 50000
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          item_valid,
  output logic                          item_stall,
  input  ppm_pkg::item_t                item,
  // result channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output ppm_pkg::result_t              result,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [ppm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ppm_pkg::CFG_W-1:0]     cfg_data
);
  import ppm_pkg::*;

  // store index width and channel counter width
  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHANNELS);

  // threshold registers
  logic [US_W-1:0]     glitch_limit_us;
  logic [US_W-1:0]     sync_limit_us;
  logic [US_W-1:0]     min_value_us;
  logic [US_W-1:0]     max_value_us;
  logic [MARGIN_W-1:0] snap_margin_us;

  // request stage
  logic  s1_valid;
  item_t s1_item;
  logic  s1_has_result;
  logic  advance;

  // frame state
  logic             frame_flag;
  logic             frame_flag_next;
  logic             armed_flag;
  logic             armed_flag_next;
  logic [CNT_W-1:0] next_channel;
  logic [CNT_W-1:0] next_channel_next;

  // datapath
  timer_ctl_t      timer_ctl;
  logic [US_W-1:0] us;
  logic [US_W-1:0] snapped;
  logic [US_W-1:0] store_rdata;
  logic            store_we;
  logic            edge_taken;
  logic            is_glitch;
  logic            is_sync;
  logic            is_full;
  edge_class_t     cls;
  result_t         result_next;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      glitch_limit_us <= GLITCH_RST;
      sync_limit_us   <= SYNC_RST;
      min_value_us    <= MIN_RST;
      max_value_us    <= MAX_RST;
      snap_margin_us  <= MARGIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GLITCH: glitch_limit_us <= cfg_data;
        REG_SYNC:   sync_limit_us   <= cfg_data;
        REG_MIN:    min_value_us    <= cfg_data;
        REG_MAX:    max_value_us    <= cfg_data;
        REG_MARGIN: snap_margin_us  <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // request stage: ticks never wait on the result side
  // ---------------------------------------------------------------------
  assign s1_has_result = (s1_item.op != OP_TICK);
  assign advance    = s1_valid && (!s1_has_result || !result_valid || !result_stall);
  assign item_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  // ---------------------------------------------------------------------
  // tick counter in microseconds
  // ---------------------------------------------------------------------
  assign edge_taken      = advance && (s1_item.op == OP_EDGE) && armed_flag;
  assign timer_ctl.tick  = advance && (s1_item.op == OP_TICK);
  assign timer_ctl.clear = edge_taken;

  ppm_timer #(
    .RELOAD (RELOAD)
  ) u_timer (
    .clk (clk),
    .rst (rst),
    .ctl (timer_ctl),
    .us  (us)
  );

  // ---------------------------------------------------------------------
  // pulse classification and snapping
  // ---------------------------------------------------------------------
  ppm_snap u_snap (
    .us        (us),
    .min_us    (min_value_us),
    .max_us    (max_value_us),
    .margin_us (snap_margin_us),
    .value     (snapped)
  );

  assign is_glitch = (us <= glitch_limit_us);
  assign is_sync   = (us > sync_limit_us);
  assign is_full   = (next_channel == MAX_CNT);

  always_comb begin
    if (!armed_flag) begin
      cls = CLS_DISARMED;
    end else if (is_glitch) begin
      cls = CLS_GLITCH;
    end else if (is_sync) begin
      cls = CLS_SYNC;
    end else if (next_channel < MAX_CNT) begin
      cls = CLS_STORED;
    end else begin
      cls = CLS_DROPPED;
    end
  end

  assign store_we = edge_taken && (cls == CLS_STORED);

  ppm_store #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .IDX_W        (IDX_W)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .we     (store_we),
    .waddr  (next_channel[IDX_W-1:0]),
    .wdata  (snapped),
    .rindex (s1_item.channel_index),
    .rdata  (store_rdata)
  );

  // ---------------------------------------------------------------------
  // frame state update
  // ---------------------------------------------------------------------
  always_comb begin
    frame_flag_next   = frame_flag;
    armed_flag_next   = armed_flag;
    next_channel_next = next_channel;
    if (edge_taken) begin
      // every taken edge drops the ready flag first
      frame_flag_next = 1'b0;
      if (cls == CLS_SYNC) begin
        if (is_full) begin
          frame_flag_next = 1'b1;
          armed_flag_next = 1'b0;
        end
        next_channel_next = '0;
      end else if (cls == CLS_STORED) begin
        next_channel_next = next_channel + 1'b1;
      end
    end else if (advance && (s1_item.op == OP_ARM)) begin
      armed_flag_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_flag   <= 1'b0;
      armed_flag   <= 1'b0;
      next_channel <= '0;
    end else begin
      frame_flag   <= frame_flag_next;
      armed_flag   <= armed_flag_next;
      next_channel <= next_channel_next;
    end
  end

  // ---------------------------------------------------------------------
  // result stage
  // ---------------------------------------------------------------------
  always_comb begin
    result_next.read_value    = (s1_item.op == OP_READ) ? store_rdata : '0;
    result_next.interval_us   = edge_taken ? us : '0;
    result_next.edge_class    = (s1_item.op == OP_EDGE) ? cls : CLS_DISARMED;
    result_next.frame_ready   = frame_flag_next;
    result_next.armed         = armed_flag_next;
    result_next.channel_count = CNT_OUT_W'(next_channel_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && s1_has_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_has_result) begin
      result <= result_next;
    end
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  // channel index never runs past the channel count
  a_chan_bound: assert property (@(posedge clk) disable iff (rst)
    next_channel <= MAX_CNT)
    else $error("channel index past channel count");

  // the decoder disarms itself only when a frame completes
  a_disarm_frame: assert property (@(posedge clk) disable iff (rst)
    $fell(armed_flag) |-> frame_flag)
    else $error("disarmed without a complete frame");

  // a frame completes only from a full channel set
  a_frame_full: assert property (@(posedge clk) disable iff (rst)
    $rose(frame_flag) |-> ($past(next_channel) == MAX_CNT) && (next_channel == '0))
    else $error("frame ready without all channels");

  // a held result is not overwritten by a request with a result
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> !(advance && s1_has_result))
    else $error("result overwritten while stalled");

endmodule

### test/tb_top.sv
// tb_top: self-checking regression for the rc ppm frame decoder
// drives tick, edge, read and arm requests, predicts each status record and compares
// depends on ppm_pkg and ppm_frame_decoder from the rtl folder
module tb_top;
  import ppm_pkg::*;

  localparam int NUM_CH       = 8;
  localparam int RELOAD_TICKS = 50000;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  item_t                item         = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;

  // idle odds in percent, and a long receiver hold-off counted in cycles
  int sender_idle   = 0;
  int receiver_idle = 0;
  int stall_hold    = 0;

  // decoded status records still due from the block, oldest first
  result_t decoded_q[$];
  int      sent_items  = 0;
  int      mismatches  = 0;
  int      cycles      = 0;

  // shadow of the decoder state and its threshold registers
  int tick_now;
  int chan_mem[NUM_CH];
  int next_ch;
  bit frame_set;
  bit is_armed;
  int lim_glitch;
  int lim_sync;
  int us_min;
  int us_max;
  int us_margin;

  ppm_frame_decoder #(
    .MAX_CHANNELS(NUM_CH),
    .RELOAD      (RELOAD_TICKS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // state after reset, register defaults from the package
  task automatic reset_shadow();
    tick_now   = 0;
    foreach (chan_mem[i]) chan_mem[i] = 0;
    next_ch    = 0;
    frame_set  = 1'b0;
    is_armed   = 1'b0;
    lim_glitch = GLITCH_RST;
    lim_sync   = SYNC_RST;
    us_min     = MIN_RST;
    us_max     = MAX_RST;
    us_margin  = MARGIN_RST;
  endtask

  // pulse width to channel value: min snap first, then max snap, then offset and clamp
  function automatic int snap_pulse(int us);
    int u;
    int v;
    u = us;
    if (u < us_min + us_margin) u = us_min;
    if (u > us_max - us_margin) u = us_max;
    v = u - us_min;
    if (v < 0) v = 0;
    if (v > 'h7FFF) v = 'h7FFF;
    return v;
  endfunction

  // advance the shadow by one request; ticks give no status record
  task automatic decode_request(input item_t req, output bit has_status,
                                output result_t st);
    int          us;
    int          rd;
    edge_class_t cls;
    us         = 0;
    rd         = 0;
    cls        = CLS_DISARMED;
    has_status = 1'b1;
    case (req.op)
      OP_TICK: begin
        has_status = 1'b0;
        // counter wraps to zero once it has reached reload minus one
        if (tick_now >= RELOAD_TICKS - 1) tick_now = 0;
        else tick_now = (tick_now + 1) & 'hFFFF;
      end
      OP_EDGE: begin
        // disarmed edges leave everything alone, the counter keeps running
        if (is_armed) begin
          us        = ((tick_now & 'hFFFF) * 4) / 10;
          tick_now  = 0;
          frame_set = 1'b0;
          if (us <= lim_glitch) begin
            cls = CLS_GLITCH;
          end else if (us > lim_sync) begin
            cls = CLS_SYNC;
            // only a sync after a full set of channels completes a frame
            if (next_ch == NUM_CH) begin
              is_armed  = 1'b0;
              frame_set = 1'b1;
            end
            next_ch = 0;
          end else if (next_ch < NUM_CH) begin
            chan_mem[next_ch] = snap_pulse(us);
            next_ch++;
            cls = CLS_STORED;
          end else begin
            // channels already full, the pulse is thrown away
            cls = CLS_DROPPED;
          end
        end
      end
      OP_READ: begin
        if (req.channel_index < NUM_CH) rd = chan_mem[req.channel_index];
      end
      default: begin
        is_armed = 1'b1;
      end
    endcase
    st.read_value    = rd[US_W-1:0];
    st.interval_us   = us[US_W-1:0];
    st.edge_class    = cls;
    st.frame_ready   = frame_set;
    st.armed         = is_armed;
    st.channel_count = next_ch[CNT_OUT_W-1:0];
  endtask

  function automatic logic [IDX_IN_W-1:0] rand_idx();
    return IDX_IN_W'($urandom_range(NUM_CH - 1));
  endfunction

  // offer one request from a falling edge until the block takes it
  task automatic send_item(input op_t op, input logic [IDX_IN_W-1:0] idx);
    item_t   req;
    bit      has_status;
    result_t st;
    req.op            = op;
    req.channel_index = idx;
    while ($urandom_range(99) < sender_idle) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= req;
    do @(posedge clk); while (item_stall);
    decode_request(req, has_status, st);
    sent_items++;
    if (has_status) begin
      decoded_q.push_back(st);
    end
    @(negedge clk);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(OP_TICK, rand_idx());
  endtask

  // rising edge after enough ticks for the wanted interval in microseconds
  task automatic pulse_us(input int us);
    int n;
    n = (us * 10 + 3) / 4 - tick_now;
    if (n > 0) send_ticks(n);
    send_item(OP_EDGE, rand_idx());
  endtask

  // stop offering, wait out every due record and the block's pipeline
  task automatic settle();
    item_valid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // write all five threshold registers while the block is idle
  task automatic apply_config(input int g, input int s, input int mn, input int mx,
                              input int mg);
    int                   vals[5];
    logic [CFG_IDX_W-1:0] regs[5];
    settle();
    vals = '{g, s, mn, mx, mg};
    regs = '{REG_GLITCH, REG_SYNC, REG_MIN, REG_MAX, REG_MARGIN};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i][CFG_W-1:0];
      @(negedge clk);
    end
    cfg_we     <= 1'b0;
    lim_glitch = g & 'h7FFF;
    lim_sync   = s & 'h7FFF;
    us_min     = mn & 'h7FFF;
    us_max     = mx & 'h7FFF;
    us_margin  = mg & 'h3FF;
  endtask

  // a read of the cleared store, a disarmed edge, double arm, default thresholds
  task automatic test_after_reset();
    send_item(OP_READ, 3'd7);
    pulse_us(4);
    send_item(OP_ARM, rand_idx());
    send_item(OP_ARM, rand_idx());
    pulse_us(20);
  endtask

  // registers at zero and at high values
  task automatic test_register_extremes();
    apply_config(20000, 20000, 20000, 20000, 1000);
    pulse_us(10);
    apply_config(0, 0, 0, 0, 0);
    pulse_us(10);
    apply_config(0, 20000, 20000, 20000, 1000);
    pulse_us(10);
    apply_config(0, 20000, 0, 20000, 0);
    pulse_us(6);
    send_item(OP_READ, 3'd1);
  endtask

  // snaps near both ends, and max below min where both snaps apply
  task automatic test_snap_rules();
    apply_config(1, 12, 4, 9, 2);
    pulse_us(5);
    pulse_us(8);
    apply_config(1, 12, 6, 3, 1);
    pulse_us(4);
  endtask

  // fill the frame, overflow it, sync to ready, disarmed edge, rearm
  task automatic test_full_frame();
    apply_config(1, 6, 2, 5, 1);
    if (!is_armed) send_item(OP_ARM, rand_idx());
    while (next_ch < NUM_CH) pulse_us($urandom_range(6, 2));
    pulse_us(4);
    pulse_us(9);
    pulse_us(3);
    send_item(OP_ARM, rand_idx());
    pulse_us(4);
  endtask

  // receiver holds off while requests keep coming, so the input backs up
  task automatic test_backpressure();
    sender_idle   = 0;
    receiver_idle = 0;
    stall_hold    = 300;
    repeat (12) send_item(OP_READ, rand_idx());
    repeat (4) send_item(OP_ARM, rand_idx());
  endtask

  // one frame with random content, sometimes short, long or with glitches
  task automatic random_frame();
    int n_ch;
    if (!is_armed && $urandom_range(9) != 0) send_item(OP_ARM, rand_idx());
    n_ch = ($urandom_range(9) < 7) ? NUM_CH : $urandom_range(NUM_CH + 2);
    for (int i = 0; i < n_ch; i++) begin
      if ($urandom_range(9) == 0) pulse_us($urandom_range(lim_glitch));
      if ($urandom_range(9) == 0) send_item(OP_READ, rand_idx());
      pulse_us($urandom_range(lim_sync, lim_glitch + 1));
    end
    pulse_us(lim_sync + $urandom_range(4, 1));
    // a captured frame is read out and the decoder rearmed, as software would
    if (frame_set) begin
      repeat ($urandom_range(3, 1)) send_item(OP_READ, rand_idx());
      if ($urandom_range(9) < 8) send_item(OP_ARM, rand_idx());
    end
  endtask

  // blocks of about a hundred requests, new thresholds for each block
  task automatic test_random_traffic();
    int goal;
    for (int blk = 0; blk < 6; blk++) begin
      case (blk / 2)
        0: begin
          sender_idle   = 29;
          receiver_idle = 86;
        end
        1: begin
          sender_idle   = 86;
          receiver_idle = 29;
        end
        default: begin
          sender_idle   = 0;
          receiver_idle = 0;
        end
      endcase
      apply_config($urandom_range(2), $urandom_range(2) + $urandom_range(5, 2),
                   $urandom_range(6), $urandom_range(8), $urandom_range(2));
      goal = sent_items + 95;
      while (sent_items < goal) begin
        if ($urandom_range(99) < 85) begin
          random_frame();
        end else begin
          // noise: a burst of ticks and any request at all
          send_ticks($urandom_range(12));
          send_item(op_t'($urandom_range(3)), rand_idx());
        end
      end
    end
  endtask

  // receiver side: random stalls, or a long hold when one is asked for
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      result_stall <= 1'b1;
      stall_hold = stall_hold - 1;
    end else begin
      result_stall <= ($urandom_range(99) < receiver_idle);
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // every accepted status record against the oldest one predicted
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (decoded_q.size() == 0) begin
        $error("status record with none predicted");
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        check_field("read_value", want.read_value, result.read_value);
        check_field("interval_us", want.interval_us, result.interval_us);
        check_field("edge_class", want.edge_class, result.edge_class);
        check_field("frame_ready", want.frame_ready, result.frame_ready);
        check_field("armed", want.armed, result.armed);
        check_field("channel_count", want.channel_count, result.channel_count);
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ppm_frame_decoder regression: fail");
      $finish;
    end
  end

  initial begin
    reset_shadow();
    sender_idle   = 29;
    receiver_idle = 86;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_after_reset();
    test_register_extremes();
    test_snap_rules();
    test_full_frame();
    test_random_traffic();
    test_backpressure();
    settle();
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("ppm_frame_decoder regression: pass");
    end else begin
      $display("ppm_frame_decoder regression: fail");
    end
    $finish;
  end

endmodule
